[rtl/lmalu_pkg.sv]
// Shared types, widths and constant functions for the lattice modular ALU.
package lmalu_pkg;

   localparam int OP_W = 3;
   localparam int DATA_W = 15;
   localparam int LOW_W = 11;
   localparam int MOD_W = 15;

   localparam int DEF_MODULUS = 12289;
   localparam int DEF_WORD_BITS = 16;
   localparam int DEF_LOG_GAMMA = 10;

   // Montgomery unit register stages; end-to-end latency of the block
   localparam int MONT_STAGES = 4;
   localparam int LATENCY = 2 * MONT_STAGES + 4;

   typedef enum logic [OP_W-1:0] {
      OP_REDUCE    = 3'd0,
      OP_TO_POS    = 3'd1,
      OP_ADD       = 3'd2,
      OP_SUB       = 3'd3,
      OP_HALVE     = 3'd4,
      OP_MONT_MUL  = 3'd5,
      OP_FULL_MUL  = 3'd6,
      OP_DECOMPOSE = 3'd7
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] res;
      logic signed [LOW_W-1:0]  low;
   } side_type;

   // -Q^-1 mod 2^64 by Newton iteration; callers keep the low word
   function automatic longint unsigned lmalu_q0i(input longint unsigned q);
      longint unsigned inv;
      inv = q;
      for (int i = 0; i < 6; i++) begin
         inv = inv * (64'd2 - q * inv);
      end
      return 64'd0 - inv;
   endfunction

   // 2^(2*w) mod q by modular doubling
   function automatic longint unsigned lmalu_r2(input longint unsigned q, input int w);
      longint unsigned r;
      r = 64'd1;
      for (int i = 0; i < 2 * w; i++) begin
         r = r << 1;
         if (r >= q) begin
            r = r - q;
         end
      end
      return r;
   endfunction

endpackage

[rtl/lmalu_mont.sv]
// Four-stage Montgomery reduction core: s = ((x*y + m*Q) mod 2^2W) >> W.
module lmalu_mont #(
   parameter int MODULUS   = lmalu_pkg::DEF_MODULUS,
   parameter int WORD_BITS = lmalu_pkg::DEF_WORD_BITS,
   parameter int OP_BITS   = lmalu_pkg::MOD_W
) (
   input  logic                 clock,
   input  logic [OP_BITS-1:0]   x,
   input  logic [OP_BITS-1:0]   y,
   output logic [WORD_BITS-1:0] s
);
   import lmalu_pkg::*;

   localparam int DW = 2 * WORD_BITS;
   localparam int PW = 2 * OP_BITS;
   localparam int WW = DW + MOD_W;
   localparam logic [WORD_BITS-1:0] Q0I = WORD_BITS'(lmalu_q0i(longint'(MODULUS)));
   localparam logic [MOD_W-1:0] QV = MOD_W'(MODULUS);

   logic [PW-1:0]        xy_prod;
   logic [DW-1:0]        m_prod;
   logic [WW-1:0]        w_prod;
   logic [DW-1:0]        sum;

   logic [DW-1:0]        z_in, z_ff;
   logic [WORD_BITS-1:0] m_in, m_ff;
   logic [DW-1:0]        zm_ff;
   logic [DW-1:0]        w_in, w_ff;
   logic [DW-1:0]        zw_ff;
   logic [WORD_BITS-1:0] s_in, s_ff;

   always_comb begin
      xy_prod = PW'(x) * PW'(y);
      z_in    = xy_prod[DW-1:0];
      m_prod  = DW'(z_ff[WORD_BITS-1:0]) * DW'(Q0I);
      m_in    = m_prod[WORD_BITS-1:0];
      w_prod  = WW'(m_ff) * WW'(QV);
      w_in    = w_prod[DW-1:0];
      sum     = zw_ff + w_ff;
      s_in    = sum[DW-1:WORD_BITS];
   end

   always_ff @(posedge clock) begin
      z_ff  <= z_in;
      m_ff  <= m_in;
      zm_ff <= z_ff;
      w_ff  <= w_in;
      zw_ff <= zm_ff;
      s_ff  <= s_in;
   end

   assign s = s_ff;

endmodule

[rtl/lattice_modular_alu_unit.sv]
// Top level of the lattice modular ALU: pipelined arithmetic modulo a small prime.
//
// Usage: drive req_op, req_operand_a and req_operand_b and raise start; the
// transaction is taken at the rising edge where start is high and busy is
// low. busy is always low, so a new transaction can be issued every cycle.
// Each transaction produces one result: rsp_valid is high for exactly one
// cycle, with rsp_result and rsp_low_part (zero unless op is decompose).
// Throughput is one transaction per cycle. The pipeline is made of two
// chained four-stage Montgomery units (the full multiply needs both), plus
// input, pre-processing, mid correction and output registers; all other
// operations ride along the same pipeline so results stay in order.
// Reset (synchronous, active high) clears all valid bits; transactions in
// flight are dropped and no result appears until new work is issued.
// The receiver cannot stall: a result is presented once and is gone.
module lattice_modular_alu_unit #(
   parameter int MODULUS   = lmalu_pkg::DEF_MODULUS,
   parameter int WORD_BITS = lmalu_pkg::DEF_WORD_BITS,
   parameter int LOG_GAMMA = lmalu_pkg::DEF_LOG_GAMMA
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [lmalu_pkg::OP_W-1:0]             req_op,
   input  logic signed [lmalu_pkg::DATA_W-1:0]    req_operand_a,
   input  logic signed [lmalu_pkg::DATA_W-1:0]    req_operand_b,
   output logic                                   rsp_valid,
   output logic signed [lmalu_pkg::DATA_W-1:0]    rsp_result,
   output logic signed [lmalu_pkg::LOW_W-1:0]     rsp_low_part
);
   import lmalu_pkg::*;

   localparam int OPW = (WORD_BITS > MOD_W) ? WORD_BITS : MOD_W;
   localparam int SW = OPW + 3;
   localparam int ALPHA_BITS = LOG_GAMMA + 1;
   localparam logic signed [SW-1:0] QS = SW'(MODULUS);
   localparam logic signed [SW-1:0] HALF = SW'(MODULUS / 2);
   localparam logic signed [SW-1:0] ONE_S = SW'(1);
   localparam logic signed [SW-1:0] ZERO_S = SW'(0);
   localparam logic [OPW-1:0] R2 = OPW'(lmalu_r2(longint'(MODULUS), WORD_BITS));

   function automatic logic signed [SW-1:0] center(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = v;
      if (v > HALF) begin
         r = v - QS;
      end else if (v < -HALF) begin
         r = v + QS;
      end
      return r;
   endfunction

   logic accept;

   // stage 1: input register
   logic                     in_vld_ff;
   op_type                   in_op_ff;
   logic signed [DATA_W-1:0] in_a_ff, in_b_ff;

   // stage 2: non-multiply ops and multiplier operands
   logic                 pre_vld_ff;
   side_type             pre_in, pre_ff;
   logic [OPW-1:0]       x1_in, x1_ff, y1_in, y1_ff;
   logic signed [SW-1:0] ae, be, pos_a, pos_b, hv, val, lo_full;
   logic [WORD_BITS-1:0] xw, yw;

   // stages 3..6 and 8..11: side data alongside the Montgomery units
   side_type               d1_ff [MONT_STAGES];
   logic [MONT_STAGES-1:0] d1_vld_ff;
   side_type               d2_ff [MONT_STAGES];
   logic [MONT_STAGES-1:0] d2_vld_ff;
   logic [WORD_BITS-1:0]   s1, s2;

   // stage 7: first Montgomery correction
   logic                 mid_vld_ff;
   side_type             mid_in, mid_ff;
   logic [OPW-1:0]       x2_in, x2_ff;
   logic signed [SW-1:0] t1, tp1;

   // stage 12: output register
   logic                     out_vld_ff;
   logic signed [DATA_W-1:0] out_res_in, out_res_ff;
   logic signed [LOW_W-1:0]  out_low_ff;
   logic signed [SW-1:0]     t2, tp2;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_comb begin
      ae      = SW'(in_a_ff);
      be      = SW'(in_b_ff);
      pos_a   = (ae < ZERO_S) ? ae + QS : ae;
      pos_b   = (be < ZERO_S) ? be + QS : be;
      hv      = ae + (in_a_ff[0] ? QS : ZERO_S);
      lo_full = SW'(signed'(in_a_ff[LOG_GAMMA:0]));
      val     = ZERO_S;
      pre_in.op  = in_op_ff;
      pre_in.low = '0;
      case (in_op_ff)
         OP_REDUCE:    val = center(ae);
         OP_TO_POS:    val = pos_a;
         OP_ADD:       val = center(ae + be);
         OP_SUB:       val = center(ae - be);
         OP_HALVE:     val = hv >>> 1;
         OP_DECOMPOSE: begin
            val = (ae >>> ALPHA_BITS) + (in_a_ff[LOG_GAMMA] ? ONE_S : ZERO_S);
            pre_in.low = LOW_W'(lo_full);
         end
         default:      val = ZERO_S;
      endcase
      pre_in.res = DATA_W'(val);
      xw    = WORD_BITS'(pos_a);
      yw    = WORD_BITS'(pos_b);
      x1_in = OPW'(xw);
      y1_in = OPW'(yw);
   end

   lmalu_mont #(
      .MODULUS   (MODULUS),
      .WORD_BITS (WORD_BITS),
      .OP_BITS   (OPW)
   ) u_mont1 (
      .clock (clock),
      .x     (x1_ff),
      .y     (y1_ff),
      .s     (s1)
   );

   always_comb begin
      t1     = SW'(s1) - QS;
      tp1    = (t1 < ZERO_S) ? t1 + QS : t1;
      mid_in = d1_ff[MONT_STAGES-1];
      if (d1_ff[MONT_STAGES-1].op == OP_MONT_MUL) begin
         mid_in.res = DATA_W'(center(t1));
      end
      x2_in = tp1[OPW-1:0];
   end

   lmalu_mont #(
      .MODULUS   (MODULUS),
      .WORD_BITS (WORD_BITS),
      .OP_BITS   (OPW)
   ) u_mont2 (
      .clock (clock),
      .x     (x2_ff),
      .y     (R2),
      .s     (s2)
   );

   always_comb begin
      t2         = SW'(s2) - QS;
      tp2        = (t2 < ZERO_S) ? t2 + QS : t2;
      out_res_in = d2_ff[MONT_STAGES-1].res;
      if (d2_ff[MONT_STAGES-1].op == OP_FULL_MUL) begin
         out_res_in = DATA_W'(center(tp2));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         pre_vld_ff <= 1'b0;
         d1_vld_ff  <= '0;
         mid_vld_ff <= 1'b0;
         d2_vld_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= accept;
         pre_vld_ff <= in_vld_ff;
         d1_vld_ff  <= {d1_vld_ff[MONT_STAGES-2:0], pre_vld_ff};
         mid_vld_ff <= d1_vld_ff[MONT_STAGES-1];
         d2_vld_ff  <= {d2_vld_ff[MONT_STAGES-2:0], mid_vld_ff};
         out_vld_ff <= d2_vld_ff[MONT_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff   <= op_type'(req_op);
      in_a_ff    <= req_operand_a;
      in_b_ff    <= req_operand_b;
      pre_ff     <= pre_in;
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      d1_ff[0]   <= pre_ff;
      for (int i = 1; i < MONT_STAGES; i++) begin
         d1_ff[i] <= d1_ff[i-1];
      end
      mid_ff     <= mid_in;
      x2_ff      <= x2_in;
      d2_ff[0]   <= mid_ff;
      for (int i = 1; i < MONT_STAGES; i++) begin
         d2_ff[i] <= d2_ff[i-1];
      end
      out_res_ff <= out_res_in;
      out_low_ff <= d2_ff[MONT_STAGES-1].low;
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_result   = out_res_ff;
   assign rsp_low_part = out_low_ff;

endmodule

[rtl/lmalu_check.sv]
// Port-level checker for the lattice modular ALU, bound to the top level.
module lmalu_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [lmalu_pkg::OP_W-1:0]          req_op,
   input logic signed [lmalu_pkg::DATA_W-1:0] req_operand_a,
   input logic                                rsp_valid,
   input logic signed [lmalu_pkg::DATA_W-1:0] rsp_result,
   input logic signed [lmalu_pkg::LOW_W-1:0]  rsp_low_part
);
   import lmalu_pkg::*;

   // every accepted transaction yields a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("missing result after accepted transaction");

   // no result without a transaction accepted out of reset
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, LATENCY))
      else $error("result without matching transaction");

   a_low_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_op, LATENCY) != OP_DECOMPOSE |-> rsp_low_part == '0)
      else $error("low part nonzero outside decompose");

   a_to_pos_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_op, LATENCY) == OP_TO_POS &&
      !$past(req_operand_a[DATA_W-1], LATENCY)
      |-> rsp_result == $past(req_operand_a, LATENCY))
      else $error("to_positive changed a nonnegative operand");

endmodule

bind lattice_modular_alu_unit lmalu_check u_lmalu_check (.*);

[sim/tb.sv]
// Testbench for lattice_modular_alu_unit: directed and random transactions checked against a predictor.
module tb;
   import lmalu_pkg::*;

   localparam int MOD_Q = DEF_MODULUS;
   localparam int MWORD = DEF_WORD_BITS;
   localparam int GAMMA_LOG = DEF_LOG_GAMMA;
   localparam longint unsigned WORD_MASK = (64'd1 << MWORD) - 64'd1;
   localparam longint unsigned DWORD_MASK = (64'd1 << (2 * MWORD)) - 64'd1;
   localparam int RANDOM_ITEMS = 1200;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      int unsigned              idle_pct;
      bit                       drain;
   } alu_req_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] result;
      logic signed [LOW_W-1:0]  low_part;
   } alu_rsp_type;

   // x such that q*x == -1 mod 2^w, built one bit at a time
   function automatic longint unsigned neg_q_inverse(input longint unsigned q, input int w);
      longint unsigned x;
      x = 0;
      for (int i = 0; i < w; i++) begin
         if ((((q * x) + 64'd1) >> i) & 64'd1) begin
            x = x | (64'd1 << i);
         end
      end
      return x;
   endfunction

   function automatic longint unsigned mont_r_squared(input longint unsigned q, input int w);
      longint unsigned r;
      r = 64'd1 % q;
      for (int i = 0; i < 2 * w; i++) begin
         r = (r << 1) % q;
      end
      return r;
   endfunction

   localparam longint unsigned MONT_QINV = neg_q_inverse(MOD_Q, MWORD);
   localparam longint unsigned MONT_R2 = mont_r_squared(MOD_Q, MWORD);

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [OP_W-1:0]          req_op = '0;
   logic signed [DATA_W-1:0] req_operand_a = '0;
   logic signed [DATA_W-1:0] req_operand_b = '0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_result;
   logic signed [LOW_W-1:0]  rsp_low_part;

   alu_req_type pending_reqs[$];
   alu_rsp_type expected_results[$];
   int       n_issued = 0;
   int       n_seen = 0;
   int       n_errors = 0;
   int       corner_vals[15] = '{-16384, 16383, -12289, 12288, -6145, -6144, 6144, 6145,
                                 -1, 0, 1, 1023, 1024, -1024, -1025};

   lattice_modular_alu_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_result    (rsp_result),
      .rsp_low_part  (rsp_low_part)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint center_mod(input longint v);
      if (v > (MOD_Q >> 1)) begin
         return v - MOD_Q;
      end else if (v < -(MOD_Q >> 1)) begin
         return v + MOD_Q;
      end
      return v;
   endfunction

   function automatic longint lift_mod(input longint v);
      return (v < 0) ? v + MOD_Q : v;
   endfunction

   // (x*y + m*Q) / R with sums kept to two words, minus Q
   function automatic longint mont_step(input longint unsigned x, input longint unsigned y);
      longint unsigned z, m, w, s;
      z = (x * y) & DWORD_MASK;
      m = (z * MONT_QINV) & WORD_MASK;
      w = (m * MOD_Q) & DWORD_MASK;
      s = ((z + w) & DWORD_MASK) >> MWORD;
      return longint'(s) - MOD_Q;
   endfunction

   function automatic alu_rsp_type predict_alu(input op_type op,
                                               input logic signed [DATA_W-1:0] a_in,
                                               input logic signed [DATA_W-1:0] b_in);
      longint a, b, v, t, lo, span;
      alu_rsp_type r;
      a = a_in;
      b = b_in;
      v = 0;
      lo = 0;
      span = longint'(1) << (GAMMA_LOG + 1);
      case (op)
         OP_REDUCE: v = center_mod(a);
         OP_TO_POS: v = lift_mod(a);
         OP_ADD: v = center_mod(a + b);
         OP_SUB: v = center_mod(a - b);
         OP_HALVE: begin
            v = a_in[0] ? a + MOD_Q : a;
            v = v >>> 1;
         end
         OP_MONT_MUL: v = center_mod(mont_step(lift_mod(a) & WORD_MASK, lift_mod(b) & WORD_MASK));
         OP_FULL_MUL: begin
            t = mont_step(lift_mod(a) & WORD_MASK, lift_mod(b) & WORD_MASK);
            if (t < 0) t = t + MOD_Q;
            t = mont_step(t, MONT_R2);
            if (t < 0) t = t + MOD_Q;
            v = center_mod(t & WORD_MASK);
         end
         default: begin
            lo = a & (span - 1);
            v = (a - lo) / span;
            if (lo >= (span >> 1)) begin
               lo = lo - span;
               v = v + 1;
            end
         end
      endcase
      r.op = op;
      r.result = v[DATA_W-1:0];
      r.low_part = lo[LOW_W-1:0];
      return r;
   endfunction

   task automatic queue_req(input op_type op, input int a, input int b,
                            input int unsigned idle_pct, input bit drain);
      alu_req_type r;
      r.op = op;
      r.a = a[DATA_W-1:0];
      r.b = b[DATA_W-1:0];
      r.idle_pct = idle_pct;
      r.drain = drain;
      pending_reqs.push_back(r);
   endtask

   function automatic int rand_operand();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
         return int'($urandom_range(0, 32767)) - 16384;
      end else if (sel == 1) begin
         return corner_vals[$urandom_range(0, 14)];
      end
      return int'($urandom_range(0, 2 * MOD_Q - 1)) - MOD_Q;
   endfunction

   task report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      n_errors++;
   endtask

   // driver
   always @(posedge clock) begin
      alu_req_type nxt;
      bit taken;
      bit hold;
      int in_flight;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            expected_results.push_back(predict_alu(op_type'(req_op), req_operand_a,
                                                   req_operand_b));
            n_issued++;
         end
         in_flight = n_issued - n_seen - (rsp_valid ? 1 : 0);
         if (start && !taken) begin
            // transaction still offered
         end else if (pending_reqs.size() == 0) begin
            start <= 1'b0;
         end else begin
            hold = (pending_reqs[0].drain && in_flight > 0) ||
                   ($urandom_range(0, 99) < pending_reqs[0].idle_pct);
            if (hold) begin
               start <= 1'b0;
            end else begin
               nxt = pending_reqs.pop_front();
               start <= 1'b1;
               req_op <= nxt.op;
               req_operand_a <= nxt.a;
               req_operand_b <= nxt.b;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      alu_rsp_type want;
      if (!reset && rsp_valid) begin
         n_seen <= n_seen + 1;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0d/%0d with no transaction outstanding",
                                      rsp_result, rsp_low_part));
         end else begin
            want = expected_results.pop_front();
            if (rsp_result !== want.result) begin
               report_mismatch($sformatf("%s result got %0d want %0d", want.op.name(),
                                         rsp_result, want.result));
            end
            if (rsp_low_part !== want.low_part) begin
               report_mismatch($sformatf("%s low_part got %0d want %0d", want.op.name(),
                                         rsp_low_part, want.low_part));
            end
         end
      end
   end

   initial begin
      int unsigned idle_pct;
      bit drain;
      queue_req(OP_REDUCE, 6144, 0, 21, 0);
      queue_req(OP_REDUCE, 6145, 0, 21, 0);
      queue_req(OP_REDUCE, -6145, 0, 21, 0);
      queue_req(OP_REDUCE, -12289, 0, 21, 0);
      queue_req(OP_REDUCE, 16383, 0, 21, 0);
      queue_req(OP_TO_POS, -1, 0, 21, 0);
      queue_req(OP_TO_POS, -16384, 0, 21, 0);
      queue_req(OP_TO_POS, 12288, 0, 21, 0);
      queue_req(OP_ADD, 12288, 12288, 21, 0);
      queue_req(OP_ADD, -12289, -12289, 21, 0);
      queue_req(OP_SUB, 12288, -12289, 21, 0);
      queue_req(OP_SUB, -16384, 16383, 21, 0);
      queue_req(OP_HALVE, -1, 0, 21, 0);
      queue_req(OP_HALVE, -12289, 0, 21, 0);
      queue_req(OP_HALVE, 12288, 0, 21, 0);
      queue_req(OP_MONT_MUL, 12288, 12288, 21, 0);
      queue_req(OP_MONT_MUL, -12289, -1, 21, 0);
      queue_req(OP_MONT_MUL, -16384, 16383, 21, 0);
      queue_req(OP_FULL_MUL, 12288, 12288, 21, 0);
      queue_req(OP_FULL_MUL, 0, -12289, 21, 0);
      queue_req(OP_FULL_MUL, -16384, -16384, 21, 0);
      queue_req(OP_DECOMPOSE, 1023, 0, 21, 0);
      queue_req(OP_DECOMPOSE, 1024, 0, 21, 0);
      queue_req(OP_DECOMPOSE, 12288, 0, 21, 0);
      queue_req(OP_DECOMPOSE, -16384, 16383, 21, 0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < RANDOM_ITEMS / 3) begin
            idle_pct = 21;
         end else if (i < 2 * RANDOM_ITEMS / 3) begin
            idle_pct = 45;
         end else begin
            idle_pct = 0;
         end
         drain = (i % (RANDOM_ITEMS / 3) == 0) || ($urandom_range(0, 149) == 0);
         queue_req(op_type'($urandom_range(0, 7)), rand_operand(), rand_operand(),
                   idle_pct, drain);
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || start || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (LATENCY + 4) @(negedge clock);
      if (n_errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
